// ===== rtl/core/pwcm_pkg.sv =====
// shared types and constants for the perspective warp coordinate map
// no dependencies

package pwcm_pkg;

	localparam int TAB_SIZE  = 32;
	localparam int FRAC_BITS = 5;
	localparam int MAX_DIM   = 4096;

	localparam int CRD_W  = 12;
	localparam int NUM_W  = 47;   // magnitude of numerators / denominator
	localparam int QW     = 41;   // saturated quotient width (cap 2^40)
	localparam int DVD_W  = NUM_W + 5 + 13; // dividend bits fed to the divider
	localparam int DIV_STEPS = DVD_W;

	localparam logic [QW-1:0] QCAP = QW'(64'd1 << 40);

	typedef enum logic [2:0] {
		REG_M0_M1 = 3'd0,
		REG_M2_M3 = 3'd1,
		REG_M4_M5 = 3'd2,
		REG_M6_M7 = 3'd3,
		REG_M8    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
	} coef_t;

endpackage

// ===== rtl/core/pwcm_if.sv =====
// valid/ready channel interfaces for the coordinate map
// depends on nothing

interface pwcm_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] dest_x;
	logic [11:0] dest_y;
	modport source (output valid, dest_x, dest_y, input ready);
	modport sink (input valid, dest_x, dest_y, output ready);
endinterface

interface pwcm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] src_x;
	logic signed [15:0] src_y;
	logic [9:0]         frac_index;
	modport source (output valid, src_x, src_y, frac_index, input ready);
	modport sink (input valid, src_x, src_y, frac_index, output ready);
endinterface

interface pwcm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/pwcm_regs.sv =====
// coefficient register file written over the configuration channel
// depends on pwcm_pkg, pwcm_if

module pwcm_regs import pwcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pwcm_cfg_if.sink   cfg,
	output coef_t      coef
);
	logic [63:0] r01_q, r23_q, r45_q, r67_q;
	logic [31:0] r8_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r01_q <= 64'h0001_0000_0000_0000;
			r23_q <= '0;
			r45_q <= 64'h0001_0000_0000_0000;
			r67_q <= '0;
			r8_q  <= 32'h0001_0000;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_M0_M1: r01_q <= cfg.data;
				REG_M2_M3: r23_q <= cfg.data;
				REG_M4_M5: r45_q <= cfg.data;
				REG_M6_M7: r67_q <= cfg.data;
				REG_M8:    r8_q  <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	assign coef.m0 = r01_q[63:32];
	assign coef.m1 = r01_q[31:0];
	assign coef.m2 = r23_q[63:32];
	assign coef.m3 = r23_q[31:0];
	assign coef.m4 = r45_q[63:32];
	assign coef.m5 = r45_q[31:0];
	assign coef.m6 = r67_q[63:32];
	assign coef.m7 = r67_q[31:0];
	assign coef.m8 = r8_q;
endmodule

// ===== rtl/core/pwcm_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating at QCAP
// depends on pwcm_pkg

module pwcm_div import pwcm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [DVD_W-1:0]     dvd,
	input  logic [NUM_W:0]       dsr,
	input  logic                 neg,
	input  logic                 zero,
	output logic                 out_valid,
	output logic [QW-1:0]        quo,
	output logic                 out_neg,
	output logic                 out_zero
);
	localparam int RW = NUM_W + 2;

	logic [DIV_STEPS:0]            v_s;
	logic [DIV_STEPS:0][RW-1:0]    r_s;
	logic [DIV_STEPS:0][QW-1:0]    q_s;
	logic [DIV_STEPS:0][DVD_W-1:0] d_s;
	logic [DIV_STEPS:0][NUM_W:0]   s_s;
	logic [DIV_STEPS:0]            n_s, z_s;

	assign v_s[0] = in_valid;
	assign r_s[0] = '0;
	assign q_s[0] = '0;
	assign d_s[0] = dvd;
	assign s_s[0] = dsr;
	assign n_s[0] = neg;
	assign z_s[0] = zero;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [RW-1:0] sh;
		logic [RW-1:0] rn;
		logic [QW:0]   qn;
		logic          ge;
		always_comb begin
			sh = {r_s[i][RW-2:0], d_s[i][DVD_W-1-i]};
			ge = sh >= RW'(s_s[i]);
			rn = ge ? sh - RW'(s_s[i]) : sh;
			qn = {q_s[i], ge};
			if (qn > (QW+1)'(QCAP))
				qn = (QW+1)'(QCAP);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1] <= rn;
				q_s[i+1] <= qn[QW-1:0];
				d_s[i+1] <= d_s[i];
				s_s[i+1] <= s_s[i];
				n_s[i+1] <= n_s[i];
				z_s[i+1] <= z_s[i];
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS];
	assign quo       = q_s[DIV_STEPS];
	assign out_neg   = n_s[DIV_STEPS];
	assign out_zero  = z_s[DIV_STEPS];
endmodule

// ===== rtl/core/pwcm_front.sv =====
// front stages: products, sums and divider operand setup
// depends on pwcm_pkg

module pwcm_front import pwcm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [CRD_W-1:0]     x,
	input  logic [CRD_W-1:0]     y,
	input  coef_t                coef,
	output logic                 out_valid,
	output logic [DVD_W-1:0]     dvd_x,
	output logic [DVD_W-1:0]     dvd_y,
	output logic [NUM_W:0]       dsr,
	output logic                 neg_x,
	output logic                 neg_y,
	output logic                 zero_x,
	output logic                 zero_y
);
	localparam int PW = 45;
	localparam int SW = 48;

	// stage 1: six products and three registered coefficients
	logic                 v_s1;
	logic signed [PW-1:0] p0_s1, p1_s1, p3_s1, p4_s1, p6_s1, p7_s1;
	logic signed [31:0]   m2_s1, m5_s1, m8_s1;
	// stage 2: sums
	logic                 v_s2;
	logic signed [SW-1:0] nx_s2, ny_s2, dn_s2;
	// stage 3: magnitudes and dividend
	logic                 v_s3;

	logic signed [CRD_W:0] xs, ys;
	assign xs = $signed({1'b0, x});
	assign ys = $signed({1'b0, y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// operands widened to the full product width before multiplying
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PW'(coef.m0) * PW'(xs);
			p1_s1 <= PW'(coef.m1) * PW'(ys);
			p3_s1 <= PW'(coef.m3) * PW'(xs);
			p4_s1 <= PW'(coef.m4) * PW'(ys);
			p6_s1 <= PW'(coef.m6) * PW'(xs);
			p7_s1 <= PW'(coef.m7) * PW'(ys);
			m2_s1 <= coef.m2;
			m5_s1 <= coef.m5;
			m8_s1 <= coef.m8;
			nx_s2 <= SW'(p0_s1) + SW'(p1_s1) + SW'(m2_s1);
			ny_s2 <= SW'(p3_s1) + SW'(p4_s1) + SW'(m5_s1);
			dn_s2 <= SW'(p6_s1) + SW'(p7_s1) + (SW'(m8_s1) <<< 12);
		end
	end

	logic [SW-1:0] ax, ay, ad;
	logic          zx, zy;
	always_comb begin
		ax = nx_s2[SW-1] ? SW'(-nx_s2) : SW'(nx_s2);
		ay = ny_s2[SW-1] ? SW'(-ny_s2) : SW'(ny_s2);
		ad = dn_s2[SW-1] ? SW'(-dn_s2) : SW'(dn_s2);
		zx = (nx_s2 == '0) || (dn_s2 == '0);
		zy = (ny_s2 == '0) || (dn_s2 == '0);
	end

	// dividend = 2*|num|*TAB_SIZE*2^12 + |den|, divisor = 2*|den|
	always_ff @(posedge clk) begin
		if (en) begin
			dvd_x  <= (DVD_W'(ax[NUM_W-1:0]) << 18) + DVD_W'(ad[NUM_W-1:0]);
			dvd_y  <= (DVD_W'(ay[NUM_W-1:0]) << 18) + DVD_W'(ad[NUM_W-1:0]);
			dsr    <= {ad[NUM_W-1:0], 1'b0};
			neg_x  <= nx_s2[SW-1] ^ dn_s2[SW-1];
			neg_y  <= ny_s2[SW-1] ^ dn_s2[SW-1];
			zero_x <= zx;
			zero_y <= zy;
		end
	end

	assign out_valid = v_s3;
endmodule

// ===== rtl/core/perspective_warp_coordinate_map.sv =====
// top level: coefficient registers, front pipeline, two dividers, output stage
// depends on pwcm_pkg, pwcm_if, pwcm_regs, pwcm_front, pwcm_div
//
// channel   dir  fields
// in        in   dest_x, dest_y
// out       out  src_x, src_y, frac_index
// cfg       in   index, data
//
// one item per cycle while not stalled; 3 front stages + 65 divider stages + 1 output stage
// the pipeline advances as a whole when the output register is free or taken
// a stall freezes every stage; nothing is dropped or repeated
// reset clears all valid bits and loads the identity matrix

module perspective_warp_coordinate_map import pwcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pwcm_in_if.sink    in,
	pwcm_out_if.source out,
	pwcm_cfg_if.sink   cfg
);
	coef_t              coef;
	logic               en;
	logic               fv;
	logic [DVD_W-1:0]   dvx, dvy;
	logic [NUM_W:0]     dsr;
	logic               nx, ny, zx, zy;
	logic               vx, vy;
	logic [QW-1:0]      qx, qy;
	logic               onx, ony, ozx, ozy;
	logic               ov_q;
	logic signed [15:0] sx_q, sy_q;
	logic [9:0]         fi_q;

	assign en       = !ov_q || out.ready;
	assign in.ready = en;

	pwcm_regs u_regs (.clk, .arst_n, .cfg, .coef);

	pwcm_front u_front (
		.clk, .arst_n, .en, .in_valid(in.valid), .x(in.dest_x), .y(in.dest_y),
		.coef, .out_valid(fv), .dvd_x(dvx), .dvd_y(dvy), .dsr,
		.neg_x(nx), .neg_y(ny), .zero_x(zx), .zero_y(zy)
	);

	pwcm_div u_divx (
		.clk, .arst_n, .en, .in_valid(fv), .dvd(dvx), .dsr, .neg(nx), .zero(zx),
		.out_valid(vx), .quo(qx), .out_neg(onx), .out_zero(ozx)
	);

	pwcm_div u_divy (
		.clk, .arst_n, .en, .in_valid(fv), .dvd(dvy), .dsr, .neg(ny), .zero(zy),
		.out_valid(vy), .quo(qy), .out_neg(ony), .out_zero(ozy)
	);

	function automatic logic [31:0] to32(input logic [QW-1:0] q, input logic n,
			input logic z);
		logic [31:0] r;
		begin
			if (z)
				r = '0;
			else if (n)
				r = (q >= QW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-q[31:0]);
			else
				r = (q >= QW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
			return r;
		end
	endfunction

	function automatic logic signed [15:0] sat16(input logic [31:0] v);
		logic signed [31:0] s;
		begin
			s = $signed(v) >>> FRAC_BITS;
			if (s > 32'sd32767)
				return 16'sh7FFF;
			else if (s < -32'sd32768)
				return 16'sh8000;
			else
				return s[15:0];
		end
	endfunction

	logic [31:0] xx, yy;
	assign xx = to32(qx, onx, ozx);
	assign yy = to32(qy, ony, ozy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (en)
			ov_q <= vx;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_q <= sat16(xx);
			sy_q <= sat16(yy);
			fi_q <= {yy[FRAC_BITS-1:0], xx[FRAC_BITS-1:0]};
		end
	end

	assign out.valid      = ov_q;
	assign out.src_x      = sx_q;
	assign out.src_y      = sy_q;
	assign out.frac_index = fi_q;

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n) vx == vy)
		else $error("divider lanes out of step");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out.ready |=> ov_q && $stable(sx_q) && $stable(fi_q))
		else $error("output beat changed under stall");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && vx && ozx && ozy |=> sx_q == 16'sd0 && sy_q == 16'sd0 && fi_q == '0)
		else $error("zero denominator gave nonzero result");
endmodule
